// ===== hdl/dtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types, constants and lookup functions for the decimal text to
// binary64 converter.
// ----------------------------------------------------------------------------
package dtd_pkg;

    // Sizing
    localparam int MAX_LEN   = 4096;
    localparam int EXP_LIMIT = 9999;
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int EXP_W     = $clog2(EXP_LIMIT + 1);

    // Restoring divide produces this many quotient bits
    localparam int DIV_STEPS = 56;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EXP   = 8'h65;
    localparam logic [7:0] CH_LOW_I = 8'h69;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    // binary64 constants
    localparam logic [63:0] DBL_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_TEN     = 64'h4024_0000_0000_0000;
    localparam logic [63:0] DBL_POS_INF = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_INF = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] DBL_POS_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    // Shared floating-point unit
    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_MUL10,
        FOP_DIV
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } fpu_stat_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PRE,
        FS_ALIGN,
        FS_DIV,
        FS_NORM,
        FS_DENORM,
        FS_ROUND,
        FS_DONE
    } fpu_state_t;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL10,
        ST_ADDD,
        ST_QDIV,
        ST_QADD,
        ST_DMUL,
        ST_SCALE,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic neg_exp;
        logic sgn_exp;
        logic neg_res;
        logic sgn_res;
        logic has_res;
        logic has_exp;
        logic in_exp;
        logic stop;
    } parse_flags_t;

    // Exact binary64 value of a decimal digit
    function automatic logic [63:0] digit_to_double(input logic [3:0] d);
        logic [63:0] v;
        unique case (d)
            4'd0:    v = 64'h0000_0000_0000_0000;
            4'd1:    v = 64'h3FF0_0000_0000_0000;
            4'd2:    v = 64'h4000_0000_0000_0000;
            4'd3:    v = 64'h4008_0000_0000_0000;
            4'd4:    v = 64'h4010_0000_0000_0000;
            4'd5:    v = 64'h4014_0000_0000_0000;
            4'd6:    v = 64'h4018_0000_0000_0000;
            4'd7:    v = 64'h401C_0000_0000_0000;
            4'd8:    v = 64'h4020_0000_0000_0000;
            4'd9:    v = 64'h4022_0000_0000_0000;
            default: v = 64'h0000_0000_0000_0000;
        endcase
        return v;
    endfunction

    // Special spellings: inf, -inf, nan, -nan
    function automatic logic [2:0] spell_len(input logic [1:0] k);
        return k[0] ? 3'd4 : 3'd3;
    endfunction

    function automatic logic [7:0] spell_char(input logic [1:0] k, input logic [1:0] i);
        logic [7:0] ch;
        unique case ({k, i})
            4'b00_00: ch = CH_LOW_I;
            4'b00_01: ch = CH_LOW_N;
            4'b00_10: ch = CH_LOW_F;
            4'b01_00: ch = CH_MINUS;
            4'b01_01: ch = CH_LOW_I;
            4'b01_10: ch = CH_LOW_N;
            4'b01_11: ch = CH_LOW_F;
            4'b10_00: ch = CH_LOW_N;
            4'b10_01: ch = CH_LOW_A;
            4'b10_10: ch = CH_LOW_N;
            4'b11_00: ch = CH_MINUS;
            4'b11_01: ch = CH_LOW_N;
            4'b11_10: ch = CH_LOW_A;
            4'b11_11: ch = CH_LOW_N;
            default:  ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [63:0] spell_bits(input logic [1:0] k);
        logic [63:0] v;
        unique case (k)
            2'd0:    v = DBL_POS_INF;
            2'd1:    v = DBL_NEG_INF;
            2'd2:    v = DBL_POS_NAN;
            default: v = DBL_NEG_NAN;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/dtd_if.sv =====
// ----------------------------------------------------------------------------
// dtd channel interfaces
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
interface dtd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;

    modport source (output valid, output text_char, input ready);
    modport sink   (input valid, input text_char, output ready);
endinterface

interface dtd_out_if import dtd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [63:0]      value_bits;
    logic [POS_W-1:0] consumed_count;
    logic             special_word;

    modport source (output valid, output value_bits, output consumed_count,
                    output special_word, input ready);
    modport sink   (input valid, input value_bits, input consumed_count,
                    input special_word, output ready);
endinterface

// ===== hdl/dtd_fpu.sv =====
// ----------------------------------------------------------------------------
// dtd_fpu
// Iterative binary64 unit for non-negative operands: add, multiply by ten
// and divide, round to nearest even, with subnormals. One shift, add or
// divide step per cycle.
// ----------------------------------------------------------------------------
module dtd_fpu import dtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpu_req_t    req,
    input  logic [63:0] x_bits,
    input  logic [63:0] y_bits,
    output fpu_stat_t   stat,
    output logic [63:0] res_bits
);

    fpu_state_t         state_reg, state_next;
    fpu_op_t            op_reg, op_next;
    logic [59:0]        xw_reg, xw_next;
    logic signed [15:0] xb_reg, xb_next;
    logic [55:0]        yw_reg, yw_next;
    logic signed [15:0] yb_reg, yb_next;
    logic [53:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               stk_reg, stk_next;
    logic [63:0]        res_reg, res_next;

    // Operand unpack helpers
    function automatic logic [55:0] unpack_sig(input logic [63:0] v);
        return {(v[62:52] != 11'd0), v[51:0], 3'b000};
    endfunction

    function automatic logic signed [15:0] unpack_exp(input logic [63:0] v);
        return (v[62:52] == 11'd0) ? 16'sd1 : $signed({5'd0, v[62:52]});
    endfunction

    // Special operands resolved at start
    logic        x_inf, y_inf, x_zero, y_zero;
    logic        spec_hit;
    logic [63:0] spec_res;

    assign x_inf  = (x_bits[62:52] == EXP_MAX);
    assign y_inf  = (y_bits[62:52] == EXP_MAX);
    assign x_zero = (x_bits[62:0] == 63'd0);
    assign y_zero = (y_bits[62:0] == 63'd0);

    always_comb
    begin
        spec_hit = 1'b0;
        spec_res = DBL_ZERO;
        unique case (req.op)
            FOP_MUL10:
            begin
                if (x_inf)
                begin
                    spec_hit = 1'b1;
                    spec_res = DBL_POS_INF;
                end
                else if (x_zero)
                begin
                    spec_hit = 1'b1;
                end
            end
            FOP_ADD:
            begin
                if (x_inf || y_inf)
                begin
                    spec_hit = 1'b1;
                    spec_res = DBL_POS_INF;
                end
                else if (x_zero)
                begin
                    spec_hit = 1'b1;
                    spec_res = y_bits;
                end
                else if (y_zero)
                begin
                    spec_hit = 1'b1;
                    spec_res = x_bits;
                end
            end
            FOP_DIV:
            begin
                if (x_zero || y_inf)
                begin
                    spec_hit = 1'b1;
                end
                else if (x_inf)
                begin
                    spec_hit = 1'b1;
                    spec_res = DBL_POS_INF;
                end
            end
            default:
            begin
                spec_hit = 1'b1;
            end
        endcase
    end

    // Shared step conditions
    logic        pre_done;
    logic        div_ge;
    logic        div_last;
    logic [53:0] div_sy;
    logic        norm_big;
    logic        norm_small;

    assign pre_done   = xw_reg[55] && yw_reg[55];
    assign div_sy     = {1'b0, yw_reg[55:3]};
    assign div_ge     = (rem_reg >= div_sy);
    assign div_last   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign norm_big   = (xw_reg[59:56] != 4'd0);
    assign norm_small = !xw_reg[55] && (xw_reg != 60'd0);

    // Rounding and packing
    logic               rnd_up;
    logic [53:0]        rnd_sum;
    logic signed [15:0] rnd_exp;
    logic [51:0]        rnd_frac;
    logic [63:0]        rnd_res;

    always_comb
    begin
        rnd_up  = xw_reg[2] && (xw_reg[1] || xw_reg[0] || stk_reg || xw_reg[3]);
        rnd_sum = {1'b0, xw_reg[55:3]} + 54'(rnd_up);
        if (rnd_sum[53])
        begin
            rnd_exp  = xb_reg + 16'sd1;
            rnd_frac = 52'd0;
        end
        else
        begin
            rnd_exp  = rnd_sum[52] ? xb_reg : 16'sd0;
            rnd_frac = rnd_sum[51:0];
        end
        if (rnd_exp >= 16'sd2047)
        begin
            rnd_res = DBL_POS_INF;
        end
        else
        begin
            rnd_res = {1'b0, rnd_exp[10:0], rnd_frac};
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    if (spec_hit)
                    begin
                        state_next = FS_DONE;
                    end
                    else if (req.op == FOP_MUL10)
                    begin
                        state_next = FS_NORM;
                    end
                    else
                    begin
                        state_next = FS_PRE;
                    end
                end
            end
            FS_PRE:
            begin
                if (pre_done)
                begin
                    state_next = (op_reg == FOP_ADD) ? FS_ALIGN : FS_DIV;
                end
            end
            FS_ALIGN:
            begin
                if (xb_reg == yb_reg)
                begin
                    state_next = FS_NORM;
                end
            end
            FS_DIV:
            begin
                if (div_last)
                begin
                    state_next = FS_NORM;
                end
            end
            FS_NORM:
            begin
                if (!norm_big && !norm_small)
                begin
                    state_next = FS_DENORM;
                end
            end
            FS_DENORM:
            begin
                if ((xw_reg == 60'd0) || (xb_reg >= 16'sd1))
                begin
                    state_next = FS_ROUND;
                end
            end
            FS_ROUND:
            begin
                state_next = FS_DONE;
            end
            FS_DONE:
            begin
                state_next = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        stat.idle = (state_reg == FS_IDLE);
        stat.done = (state_reg == FS_DONE);
    end

    assign res_bits = res_reg;

    // Datapath
    always_comb
    begin
        op_next  = op_reg;
        xw_next  = xw_reg;
        xb_next  = xb_reg;
        yw_next  = yw_reg;
        yb_next  = yb_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        stk_next = stk_reg;
        res_next = res_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    xw_next  = {4'd0, unpack_sig(x_bits)};
                    xb_next  = unpack_exp(x_bits);
                    yw_next  = unpack_sig(y_bits);
                    yb_next  = unpack_exp(y_bits);
                    stk_next = 1'b0;
                    res_next = spec_res;
                    if (req.op == FOP_MUL10)
                    begin
                        // sig * 10 as sig * 8 + sig * 2
                        xw_next = ({4'd0, unpack_sig(x_bits)} << 3)
                                + ({4'd0, unpack_sig(x_bits)} << 1);
                    end
                end
            end
            FS_PRE:
            begin
                // Bring subnormal operands to a leading one
                if (!xw_reg[55])
                begin
                    xw_next = xw_reg << 1;
                    xb_next = xb_reg - 16'sd1;
                end
                if (!yw_reg[55])
                begin
                    yw_next = yw_reg << 1;
                    yb_next = yb_reg - 16'sd1;
                end
                if (pre_done && (op_reg != FOP_ADD))
                begin
                    rem_next = {1'b0, xw_reg[55:3]};
                    xw_next  = 60'd0;
                    cnt_next = '0;
                end
            end
            FS_ALIGN:
            begin
                // Shift the smaller operand right, losing bits into sticky
                if (xb_reg == yb_reg)
                begin
                    xw_next = xw_reg + {4'd0, yw_reg};
                end
                else if (xb_reg > yb_reg)
                begin
                    if (yw_reg == 56'd0)
                    begin
                        yb_next = xb_reg;
                    end
                    else
                    begin
                        yw_next  = yw_reg >> 1;
                        stk_next = stk_reg | yw_reg[0];
                        yb_next  = yb_reg + 16'sd1;
                    end
                end
                else
                begin
                    if (xw_reg == 60'd0)
                    begin
                        xb_next = yb_reg;
                    end
                    else
                    begin
                        xw_next  = xw_reg >> 1;
                        stk_next = stk_reg | xw_reg[0];
                        xb_next  = xb_reg + 16'sd1;
                    end
                end
            end
            FS_DIV:
            begin
                // One restoring quotient bit per cycle
                rem_next = (div_ge ? (rem_reg - div_sy) : rem_reg) << 1;
                xw_next  = {xw_reg[58:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    stk_next = (rem_next != 54'd0);
                    xb_next  = xb_reg - yb_reg + 16'sd1023;
                end
            end
            FS_NORM:
            begin
                if (norm_big)
                begin
                    xw_next  = xw_reg >> 1;
                    stk_next = stk_reg | xw_reg[0];
                    xb_next  = xb_reg + 16'sd1;
                end
                else if (norm_small)
                begin
                    xw_next = xw_reg << 1;
                    xb_next = xb_reg - 16'sd1;
                end
            end
            FS_DENORM:
            begin
                // Below the normal range: shift right to the subnormal scale
                if (xw_reg == 60'd0)
                begin
                    xb_next = 16'sd1;
                end
                else if (xb_reg < 16'sd1)
                begin
                    xw_next  = xw_reg >> 1;
                    stk_next = stk_reg | xw_reg[0];
                    xb_next  = xb_reg + 16'sd1;
                end
            end
            FS_ROUND:
            begin
                res_next = rnd_res;
            end
            FS_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        xw_reg  <= xw_next;
        xb_reg  <= xb_next;
        yw_reg  <= yw_next;
        yb_reg  <= yb_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        stk_reg <= stk_next;
        res_reg <= res_next;
    end

endmodule

// ===== hdl/decimal_text_to_double.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_double
// Parses a decimal string, one character per transaction, into a binary64
// bit pattern with the count of characters consumed.
// ----------------------------------------------------------------------------
// Each character is taken in one transaction; the block then holds ready low
// while it works. Signs, points, 'e', exponent digits and ignored characters
// are handled without leaving the idle state. An integer digit runs a multiply
// by ten and an add through the shared floating-point unit. A fraction digit
// runs a 56-step restoring divide of the digit by the current divisor, an add
// to the value and a multiply of the divisor by ten.
// On the terminating zero the value is scaled once per exponent step, by a
// multiply by ten upward or a divide by ten downward, for up to 9999 steps;
// the special spellings skip scaling. The result then waits in an output
// register until taken, after which the block accepts the next string.
// All arithmetic runs on the one shared unit, which does a single shift, add
// or divide step per cycle.
// ----------------------------------------------------------------------------
module decimal_text_to_double import dtd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dtd_in_if.sink     text,
    dtd_out_if.source  result
);

    ctl_state_t       state_reg, state_next;
    logic [63:0]      m_reg, m_next;
    logic [63:0]      div_reg, div_next;
    logic [63:0]      t_reg, t_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    parse_flags_t     flags_reg, flags_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] stop_reg, stop_next;
    logic [3:0]       match_reg, match_next;
    logic [3:0]       dig_reg, dig_next;
    logic [63:0]      value_reg, value_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic             special_reg, special_next;
    logic             launched_reg, launched_next;

    // Shared floating-point unit
    fpu_req_t    fpu_req;
    fpu_stat_t   fpu_stat;
    logic [63:0] fpu_x, fpu_y, fpu_res;
    logic        op_state;

    dtd_fpu u_fpu (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (fpu_req),
        .x_bits   (fpu_x),
        .y_bits   (fpu_y),
        .stat     (fpu_stat),
        .res_bits (fpu_res)
    );

    // Input decode
    logic       acc_in;
    logic [7:0] ch;
    logic       is_digit;

    assign acc_in   = text.valid && text.ready;
    assign ch       = text.text_char;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

    // Exponent digit with saturation
    logic [EXP_W+3:0] exp_mul;
    logic [EXP_W-1:0] exp_sat;

    always_comb
    begin
        exp_mul = ((EXP_W+4)'(exp_reg) << 3) + ((EXP_W+4)'(exp_reg) << 1)
                + (EXP_W+4)'(ch[3:0]);
        exp_sat = (exp_mul > (EXP_W+4)'(EXP_LIMIT)) ? EXP_W'(EXP_LIMIT)
                                                    : exp_mul[EXP_W-1:0];
    end

    // Special spelling tracking and final lookup
    logic [3:0]  match_upd;
    logic        spec_hit;
    logic [1:0]  spec_idx;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            match_upd[k] = match_reg[k];
            if ((pos_reg >= POS_W'(spell_len(2'(k))))
                || (spell_char(2'(k), pos_reg[1:0]) != ch))
            begin
                match_upd[k] = 1'b0;
            end
        end
        spec_hit = 1'b0;
        spec_idx = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (match_reg[k] && (pos_reg == POS_W'(spell_len(2'(k)))))
            begin
                spec_hit = 1'b1;
                spec_idx = 2'(k);
            end
        end
    end

    // Consumed count with dangling exponent and lone sign backed out
    logic [POS_W-1:0] cnt_base, cnt_exp, cnt_fin;

    always_comb
    begin
        cnt_base = flags_reg.stop ? stop_reg : pos_reg;
        cnt_exp  = cnt_base;
        if (flags_reg.in_exp && !flags_reg.has_exp)
        begin
            if (flags_reg.sgn_exp)
            begin
                cnt_exp = (cnt_base >= POS_W'(2)) ? cnt_base - POS_W'(2) : '0;
            end
            else
            begin
                cnt_exp = (cnt_base >= POS_W'(1)) ? cnt_base - POS_W'(1) : '0;
            end
        end
        cnt_fin = cnt_exp;
        if (!flags_reg.has_res && flags_reg.sgn_res)
        begin
            cnt_fin = (cnt_exp >= POS_W'(1)) ? cnt_exp - POS_W'(1) : '0;
        end
    end

    // Operation select for the shared unit
    always_comb
    begin
        fpu_req.op = FOP_ADD;
        fpu_x      = m_reg;
        fpu_y      = m_reg;
        op_state   = 1'b0;
        unique case (state_reg)
            ST_MUL10:
            begin
                fpu_req.op = FOP_MUL10;
                op_state   = 1'b1;
            end
            ST_ADDD:
            begin
                fpu_y    = digit_to_double(dig_reg);
                op_state = 1'b1;
            end
            ST_QDIV:
            begin
                fpu_req.op = FOP_DIV;
                fpu_x      = digit_to_double(dig_reg);
                fpu_y      = div_reg;
                op_state   = 1'b1;
            end
            ST_QADD:
            begin
                fpu_y    = t_reg;
                op_state = 1'b1;
            end
            ST_DMUL:
            begin
                fpu_req.op = FOP_MUL10;
                fpu_x      = div_reg;
                op_state   = 1'b1;
            end
            ST_SCALE:
            begin
                fpu_req.op = flags_reg.neg_exp ? FOP_DIV : FOP_MUL10;
                fpu_y      = DBL_TEN;
                op_state   = (exp_reg != '0);
            end
            ST_IDLE, ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
        fpu_req.start = op_state && !launched_reg && fpu_stat.idle;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    if (ch == CH_NUL)
                    begin
                        state_next = spec_hit ? ST_OUT : ST_SCALE;
                    end
                    else if (!flags_reg.stop && is_digit && !flags_reg.in_exp)
                    begin
                        state_next = (div_reg == DBL_ZERO) ? ST_MUL10 : ST_QDIV;
                    end
                end
            end
            ST_MUL10:
            begin
                if (fpu_stat.done)
                begin
                    state_next = ST_ADDD;
                end
            end
            ST_ADDD:
            begin
                if (fpu_stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QDIV:
            begin
                if (fpu_stat.done)
                begin
                    state_next = ST_QADD;
                end
            end
            ST_QADD:
            begin
                if (fpu_stat.done)
                begin
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL:
            begin
                if (fpu_stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                if (exp_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Channel outputs
    always_comb
    begin
        text.ready            = (state_reg == ST_IDLE);
        result.valid          = (state_reg == ST_OUT);
        result.value_bits     = value_reg;
        result.consumed_count = count_reg;
        result.special_word   = special_reg;
    end

    // Datapath
    always_comb
    begin
        m_next        = m_reg;
        div_next      = div_reg;
        t_next        = t_reg;
        exp_next      = exp_reg;
        flags_next    = flags_reg;
        pos_next      = pos_reg;
        stop_next     = stop_reg;
        match_next    = match_reg;
        dig_next      = dig_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        special_next  = special_reg;
        launched_next = launched_reg;

        if (fpu_req.start)
        begin
            launched_next = 1'b1;
        end
        if (fpu_stat.done)
        begin
            launched_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_in && (ch != CH_NUL))
                begin
                    match_next = match_upd;
                    if (pos_reg < POS_W'(MAX_LEN))
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (!flags_reg.stop)
                    begin
                        if (is_digit)
                        begin
                            dig_next = ch[3:0];
                            if (flags_reg.in_exp)
                            begin
                                exp_next           = exp_sat;
                                flags_next.has_exp = 1'b1;
                            end
                            else if (div_reg == DBL_ZERO)
                            begin
                                flags_next.has_res = 1'b1;
                            end
                        end
                        else if (ch == CH_POINT)
                        begin
                            if (!flags_reg.has_res || flags_reg.in_exp
                                || (div_reg != DBL_ZERO))
                            begin
                                flags_next.stop = 1'b1;
                                stop_next       = pos_reg;
                            end
                            else
                            begin
                                div_next = DBL_TEN;
                            end
                        end
                        else if ((ch == CH_MINUS) || (ch == CH_PLUS))
                        begin
                            if (flags_reg.in_exp)
                            begin
                                if (flags_reg.sgn_exp || (exp_reg != '0))
                                begin
                                    flags_next.stop = 1'b1;
                                    stop_next       = pos_reg;
                                end
                                else
                                begin
                                    flags_next.sgn_exp = 1'b1;
                                    flags_next.neg_exp = (ch == CH_MINUS);
                                end
                            end
                            else
                            begin
                                if (flags_reg.sgn_res || (m_reg != DBL_ZERO))
                                begin
                                    flags_next.stop = 1'b1;
                                    stop_next       = pos_reg;
                                end
                                else
                                begin
                                    flags_next.sgn_res = 1'b1;
                                    flags_next.neg_res = (ch == CH_MINUS);
                                end
                            end
                        end
                        else if (ch == CH_EXP)
                        begin
                            if (!flags_reg.has_res || flags_reg.in_exp)
                            begin
                                flags_next.stop = 1'b1;
                                stop_next       = pos_reg;
                            end
                            else
                            begin
                                flags_next.in_exp = 1'b1;
                            end
                        end
                        else
                        begin
                            flags_next.stop = 1'b1;
                            stop_next       = pos_reg;
                        end
                    end
                end
                else if (acc_in)
                begin
                    // Terminator: settle count and special spelling
                    special_next = spec_hit;
                    if (spec_hit)
                    begin
                        value_next = spell_bits(spec_idx);
                        count_next = POS_W'(spell_len(spec_idx));
                    end
                    else
                    begin
                        count_next = cnt_fin;
                    end
                end
            end
            ST_MUL10, ST_ADDD, ST_QADD:
            begin
                if (fpu_stat.done)
                begin
                    m_next = fpu_res;
                end
            end
            ST_QDIV:
            begin
                if (fpu_stat.done)
                begin
                    t_next = fpu_res;
                end
            end
            ST_DMUL:
            begin
                if (fpu_stat.done)
                begin
                    div_next = fpu_res;
                end
            end
            ST_SCALE:
            begin
                if (exp_reg == '0)
                begin
                    // Apply sign; zero stays +0.0
                    if (flags_reg.neg_res && (m_reg != DBL_ZERO))
                    begin
                        value_next = {~m_reg[63], m_reg[62:0]};
                    end
                    else
                    begin
                        value_next = m_reg;
                    end
                end
                else if (fpu_stat.done)
                begin
                    m_next   = fpu_res;
                    exp_next = exp_reg - EXP_W'(1);
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    m_next     = DBL_ZERO;
                    div_next   = DBL_ZERO;
                    exp_next   = '0;
                    flags_next = '0;
                    pos_next   = '0;
                    stop_next  = '0;
                    match_next = 4'hF;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_reg        <= DBL_ZERO;
            div_reg      <= DBL_ZERO;
            exp_reg      <= '0;
            flags_reg    <= '0;
            pos_reg      <= '0;
            stop_reg     <= '0;
            match_reg    <= 4'hF;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_reg        <= m_next;
            div_reg      <= div_next;
            exp_reg      <= exp_next;
            flags_reg    <= flags_next;
            pos_reg      <= pos_next;
            stop_reg     <= stop_next;
            match_reg    <= match_next;
            launched_reg <= launched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        dig_reg     <= dig_next;
        value_reg   <= value_next;
        count_reg   <= count_next;
        special_reg <= special_next;
    end

endmodule

// ===== hdl/dtd_checker.sv =====
// ----------------------------------------------------------------------------
// dtd_checker
// Port-level checks on the converter, attached by bind.
// ----------------------------------------------------------------------------
module dtd_checker import dtd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic [7:0]       in_char,
    input logic             out_valid,
    input logic [63:0]      value_bits,
    input logic [POS_W-1:0] consumed_count,
    input logic             special_word
);

    // No new character while a result is waiting
    a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // Only the terminator can produce a result
    a_result_after_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_char != CH_NUL)) |=> !out_valid)
        else $error("result after a non-terminating character");

    // Special spellings give inf or nan
    a_special_exponent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && special_word) |-> (value_bits[62:52] == EXP_MAX))
        else $error("special result without all-ones exponent");

    // Special spellings are three or four characters long
    a_special_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && special_word) |->
            ((consumed_count == POS_W'(3)) || (consumed_count == POS_W'(4))))
        else $error("special result with wrong count");

    // Count never exceeds the maximum length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (consumed_count <= POS_W'(MAX_LEN)))
        else $error("consumed count beyond maximum length");

endmodule

bind decimal_text_to_double dtd_checker u_dtd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (text.valid),
    .in_ready       (text.ready),
    .in_char        (text.text_char),
    .out_valid      (result.valid),
    .value_bits     (result.value_bits),
    .consumed_count (result.consumed_count),
    .special_word   (result.special_word)
);
